### rtl/core/c2s_pkg.sv
// Shared types, angle constants and arctangent table for the cartesian to spherical unit.
`default_nettype none

package c2s_pkg;

    typedef logic [31:0] angle_t;

    typedef struct packed {
        logic valid;
        logic bypass;
    } c2s_ctl_t;

    localparam int     GUARD_BITS    = 8;
    localparam int     ATAN_ENTRIES  = 32;
    localparam angle_t INV_GAIN_Q32  = 32'h9B74_EDA8;
    localparam angle_t ANGLE_QUARTER = 32'h4000_0000;
    localparam angle_t ANGLE_HALF    = 32'h8000_0000;
    localparam angle_t ANGLE_NEG_QUARTER = 32'hC000_0000;
    localparam logic signed [31:0] LAT_MAX = 32'sh4000_0000;
    localparam logic signed [31:0] LAT_MIN = -32'sh4000_0000;

    localparam angle_t ATAN_ROM [ATAN_ENTRIES] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    function automatic angle_t atan_entry(input int idx);
        logic [4:0] sel;
        sel = idx[4:0];
        if (idx < ATAN_ENTRIES)
        begin
            atan_entry = ATAN_ROM[sel];
        end
        else
        begin
            atan_entry = '0;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/c2s_vec_stage.sv
// One registered CORDIC vectoring iteration with a fixed shift, or a registered pass-through when bypass is set.
`default_nettype none

module c2s_vec_stage
    import c2s_pkg::*;
#(
    parameter int DW        = 44,
    parameter int SIDE_W    = 32,
    parameter int STAGE_IDX = 0
)
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     en,
    input  wire c2s_ctl_t           in_ctl,
    input  wire logic signed [DW-1:0] in_x,
    input  wire logic signed [DW-1:0] in_y,
    input  wire angle_t             in_ang,
    input  wire logic [SIDE_W-1:0]  in_side,
    output c2s_ctl_t                out_ctl,
    output logic signed [DW-1:0]    out_x,
    output logic signed [DW-1:0]    out_y,
    output angle_t                  out_ang,
    output logic [SIDE_W-1:0]       out_side
);

    localparam angle_t STEP_ANGLE = atan_entry(STAGE_IDX);

    c2s_ctl_t              ctl_reg;
    logic signed [DW-1:0]  x_reg, x_next;
    logic signed [DW-1:0]  y_reg, y_next;
    angle_t                ang_reg, ang_next;
    logic [SIDE_W-1:0]     side_reg;
    logic signed [DW-1:0]  dx, dy;

    always_comb
    begin
        dx = in_y >>> STAGE_IDX;
        dy = in_x >>> STAGE_IDX;
        if (in_ctl.bypass)
        begin
            x_next   = in_x;
            y_next   = in_y;
            ang_next = in_ang;
        end
        else if (!in_y[DW-1])
        begin
            x_next   = in_x + dx;
            y_next   = in_y - dy;
            ang_next = in_ang + STEP_ANGLE;
        end
        else
        begin
            x_next   = in_x - dx;
            y_next   = in_y + dy;
            ang_next = in_ang - STEP_ANGLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_ctl  = ctl_reg;
    assign out_x    = x_reg;
    assign out_y    = y_reg;
    assign out_ang  = ang_reg;
    assign out_side = side_reg;

endmodule

`default_nettype wire

### rtl/core/c2s_gain.sv
// Two-stage CORDIC gain correction: split multiply by 1/K, then round and sum; bypass passes the input through.
`default_nettype none

module c2s_gain
    import c2s_pkg::*;
#(
    parameter int DW     = 44,
    parameter int SIDE_W = 32
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire c2s_ctl_t            in_ctl,
    input  wire logic [DW-2:0]       in_a,
    input  wire logic [SIDE_W-1:0]   in_side,
    output c2s_ctl_t                 out_ctl,
    output logic [DW-2:0]            out_mag,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int AW = DW - 1;
    localparam int AP = (AW > 32) ? AW : 33;
    localparam int HW = AP - 32;
    localparam logic [64:0] ROUND_HALF = 65'h0_8000_0000;

    logic [AP-1:0]     a_ext;
    logic [31:0]       a_lo;
    logic [HW-1:0]     a_hi;

    c2s_ctl_t          ctl1_reg;
    logic [63:0]       plo_reg, plo_next;
    logic [AP-1:0]     phi_reg, phi_next;
    logic [AW-1:0]     a_reg;
    logic [SIDE_W-1:0] side1_reg;

    c2s_ctl_t          ctl2_reg;
    logic [AW-1:0]     mag_reg, mag_next;
    logic [SIDE_W-1:0] side2_reg;

    logic [32:0]       rnd;
    logic [AP:0]       prod_sum;

    assign a_ext    = AP'(in_a);
    assign a_lo     = a_ext[31:0];
    assign a_hi     = a_ext[AP-1:32];
    assign plo_next = 64'(a_lo) * 64'(INV_GAIN_Q32);
    assign phi_next = AP'(a_hi) * AP'(INV_GAIN_Q32);

    assign rnd      = 33'((65'(plo_reg) + ROUND_HALF) >> 32);
    assign prod_sum = (AP+1)'(phi_reg) + (AP+1)'(rnd);
    assign mag_next = ctl1_reg.bypass ? a_reg : prod_sum[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg   <= plo_next;
            phi_reg   <= phi_next;
            a_reg     <= in_a;
            side1_reg <= in_side;
            mag_reg   <= mag_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_ctl  = ctl2_reg;
    assign out_mag  = mag_reg;
    assign out_side = side2_reg;

endmodule

`default_nettype wire

### rtl/core/cartesian_to_spherical_unit.sv
// Top level: pipelined cartesian to spherical conversion by two CORDIC vectoring passes.
// One point enters per cycle while the pipeline is not held; its result passes through
// an input register, one register per CORDIC iteration of the longitude pass, two
// gain-correction stages, a latitude set-up register, one register per iteration of the
// latitude pass, two more gain-correction stages and the output register. While the output
// transaction waits, the pipeline holds as a whole; an empty input register still takes
// one point during the wait. Radius is at the input scale, rounded half up and saturated
// to 32 bits; angles are binary with 2^31 for pi, latitude clamped to +-2^30, and the
// origin and the z axis give a longitude of 0.
`default_nettype none

module cartesian_to_spherical_unit
    import c2s_pkg::*;
#(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 32
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               point_valid,
    output logic              point_ready,
    input  wire logic [31:0]  x_coord,
    input  wire logic [31:0]  y_coord,
    input  wire logic [31:0]  z_coord,
    output logic              result_valid,
    input  wire               result_ready,
    output logic [31:0]       radius,
    output logic [31:0]       latitude,
    output logic [31:0]       longitude
);

    localparam int IN_W = (COORD_WIDTH > 32) ? 33 : COORD_WIDTH;
    localparam int DW   = IN_W + GUARD_BITS + 3;
    localparam int AW   = DW - 1;
    localparam int RW   = (AW + 1 - GUARD_BITS > 33) ? (AW + 1 - GUARD_BITS) : 33;
    localparam logic [AW:0] RAD_ROUND = (AW+1)'(1) << (GUARD_BITS - 1);

    logic pipe_en;
    logic prep_en;

    // input register
    logic signed [IN_W-1:0] xs, ys, zs;
    logic signed [DW-1:0]   xg, yg, zg;
    logic                   p_bypass;
    logic signed [DW-1:0]   p_x, p_y;
    angle_t                 p_ang;

    c2s_ctl_t               prep_ctl_reg, prep_ctl_next;
    logic signed [DW-1:0]   prep_x_reg, prep_y_reg, prep_z_reg;
    angle_t                 prep_ang_reg;

    // longitude pass
    c2s_ctl_t               v1_ctl  [CORDIC_STAGES+1];
    logic signed [DW-1:0]   v1_x    [CORDIC_STAGES+1];
    logic signed [DW-1:0]   v1_y    [CORDIC_STAGES+1];
    angle_t                 v1_ang  [CORDIC_STAGES+1];
    logic [DW-1:0]          v1_side [CORDIC_STAGES+1];

    c2s_ctl_t               g1_ctl;
    logic [AW-1:0]          g1_mag;
    logic [DW+31:0]         g1_side;

    // latitude set-up register
    angle_t                 q_lon;
    logic signed [DW-1:0]   q_z;
    logic                   q_bypass;
    logic signed [DW-1:0]   q_h, q_v;
    angle_t                 q_ang;

    c2s_ctl_t               q_ctl_reg, q_ctl_next;
    logic signed [DW-1:0]   q_h_reg, q_v_reg;
    angle_t                 q_ang_reg, q_lon_reg;

    // latitude pass
    c2s_ctl_t               v2_ctl  [CORDIC_STAGES+1];
    logic signed [DW-1:0]   v2_x    [CORDIC_STAGES+1];
    logic signed [DW-1:0]   v2_y    [CORDIC_STAGES+1];
    angle_t                 v2_ang  [CORDIC_STAGES+1];
    angle_t                 v2_side [CORDIC_STAGES+1];

    c2s_ctl_t               g2_ctl;
    logic [AW-1:0]          g2_mag;
    logic [63:0]            g2_side;

    // output register
    logic signed [31:0]     lat_raw;
    angle_t                 lat_next;
    logic [AW:0]            rad_sum;
    logic [RW-1:0]          rad_full;
    logic [31:0]            rad_next;

    logic                   result_valid_reg;
    logic [31:0]            radius_reg, latitude_reg, longitude_reg;

    assign pipe_en     = !result_valid_reg || result_ready;
    assign prep_en     = pipe_en || !prep_ctl_reg.valid;
    assign point_ready = prep_en;

    generate
        if (COORD_WIDTH > 32)
        begin : g_wide
            assign xs = {1'b0, x_coord};
            assign ys = {1'b0, y_coord};
            assign zs = {1'b0, z_coord};
        end
        else
        begin : g_narrow
            assign xs = x_coord[IN_W-1:0];
            assign ys = y_coord[IN_W-1:0];
            assign zs = z_coord[IN_W-1:0];
        end
    endgenerate

    assign xg = DW'(xs) <<< GUARD_BITS;
    assign yg = DW'(ys) <<< GUARD_BITS;
    assign zg = DW'(zs) <<< GUARD_BITS;

    // bypass on the x axis; fold the rest of the left half plane by a quarter turn
    always_comb
    begin
        p_bypass = 1'b0;
        p_x      = xg;
        p_y      = yg;
        p_ang    = '0;
        if (xg == '0 && yg == '0)
        begin
            p_bypass = 1'b1;
        end
        else if (yg == '0)
        begin
            p_bypass = 1'b1;
            if (xg[DW-1])
            begin
                p_x   = -xg;
                p_ang = ANGLE_HALF;
            end
        end
        else if (xg[DW-1])
        begin
            if (!yg[DW-1])
            begin
                p_x   = yg;
                p_y   = -xg;
                p_ang = ANGLE_QUARTER;
            end
            else
            begin
                p_x   = -yg;
                p_y   = xg;
                p_ang = ANGLE_NEG_QUARTER;
            end
        end
    end

    assign prep_ctl_next = '{valid: point_valid, bypass: p_bypass};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_ctl_reg <= '0;
        end
        else if (prep_en)
        begin
            prep_ctl_reg <= prep_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_en)
        begin
            prep_x_reg   <= p_x;
            prep_y_reg   <= p_y;
            prep_z_reg   <= zg;
            prep_ang_reg <= p_ang;
        end
    end

    assign v1_ctl[0]  = prep_ctl_reg;
    assign v1_x[0]    = prep_x_reg;
    assign v1_y[0]    = prep_y_reg;
    assign v1_ang[0]  = prep_ang_reg;
    assign v1_side[0] = prep_z_reg;

    generate
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_pass1
            c2s_vec_stage #(
                .DW        (DW),
                .SIDE_W    (DW),
                .STAGE_IDX (i)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (pipe_en),
                .in_ctl   (v1_ctl[i]),
                .in_x     (v1_x[i]),
                .in_y     (v1_y[i]),
                .in_ang   (v1_ang[i]),
                .in_side  (v1_side[i]),
                .out_ctl  (v1_ctl[i+1]),
                .out_x    (v1_x[i+1]),
                .out_y    (v1_y[i+1]),
                .out_ang  (v1_ang[i+1]),
                .out_side (v1_side[i+1])
            );
        end
    endgenerate

    c2s_gain #(
        .DW     (DW),
        .SIDE_W (DW + 32)
    ) u_gain_hyp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_ctl   (v1_ctl[CORDIC_STAGES]),
        .in_a     (v1_x[CORDIC_STAGES][AW-1:0]),
        .in_side  ({v1_ang[CORDIC_STAGES], v1_side[CORDIC_STAGES]}),
        .out_ctl  (g1_ctl),
        .out_mag  (g1_mag),
        .out_side (g1_side)
    );

    assign q_lon = g1_side[DW+31:DW];
    assign q_z   = g1_side[DW-1:0];

    // bypass the second pass on the z axis and in the equatorial plane
    always_comb
    begin
        q_bypass = 1'b0;
        q_h      = {1'b0, g1_mag};
        q_v      = q_z;
        q_ang    = '0;
        if (g1_mag == '0)
        begin
            q_bypass = 1'b1;
            q_v      = '0;
            if (q_z[DW-1])
            begin
                q_h   = -q_z;
                q_ang = ANGLE_NEG_QUARTER;
            end
            else
            begin
                q_h = q_z;
                if (q_z != '0)
                begin
                    q_ang = ANGLE_QUARTER;
                end
            end
        end
        else if (q_z == '0)
        begin
            q_bypass = 1'b1;
        end
    end

    assign q_ctl_next = '{valid: g1_ctl.valid, bypass: q_bypass};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_ctl_reg <= '0;
        end
        else if (pipe_en)
        begin
            q_ctl_reg <= q_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            q_h_reg   <= q_h;
            q_v_reg   <= q_v;
            q_ang_reg <= q_ang;
            q_lon_reg <= q_lon;
        end
    end

    assign v2_ctl[0]  = q_ctl_reg;
    assign v2_x[0]    = q_h_reg;
    assign v2_y[0]    = q_v_reg;
    assign v2_ang[0]  = q_ang_reg;
    assign v2_side[0] = q_lon_reg;

    generate
        for (genvar j = 0; j < CORDIC_STAGES; j++)
        begin : g_pass2
            c2s_vec_stage #(
                .DW        (DW),
                .SIDE_W    (32),
                .STAGE_IDX (j)
            ) u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (pipe_en),
                .in_ctl   (v2_ctl[j]),
                .in_x     (v2_x[j]),
                .in_y     (v2_y[j]),
                .in_ang   (v2_ang[j]),
                .in_side  (v2_side[j]),
                .out_ctl  (v2_ctl[j+1]),
                .out_x    (v2_x[j+1]),
                .out_y    (v2_y[j+1]),
                .out_ang  (v2_ang[j+1]),
                .out_side (v2_side[j+1])
            );
        end
    endgenerate

    c2s_gain #(
        .DW     (DW),
        .SIDE_W (64)
    ) u_gain_mag (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_ctl   (v2_ctl[CORDIC_STAGES]),
        .in_a     (v2_x[CORDIC_STAGES][AW-1:0]),
        .in_side  ({v2_ang[CORDIC_STAGES], v2_side[CORDIC_STAGES]}),
        .out_ctl  (g2_ctl),
        .out_mag  (g2_mag),
        .out_side (g2_side)
    );

    // clamp latitude overshoot, round and saturate the radius
    assign lat_raw = g2_side[63:32];

    always_comb
    begin
        if (lat_raw > LAT_MAX)
        begin
            lat_next = ANGLE_QUARTER;
        end
        else if (lat_raw < LAT_MIN)
        begin
            lat_next = ANGLE_NEG_QUARTER;
        end
        else
        begin
            lat_next = lat_raw;
        end
    end

    assign rad_sum  = (AW+1)'(g2_mag) + RAD_ROUND;
    assign rad_full = RW'(rad_sum >> GUARD_BITS);
    assign rad_next = (|rad_full[RW-1:32]) ? 32'hFFFF_FFFF : rad_full[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            result_valid_reg <= g2_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            radius_reg    <= rad_next;
            latitude_reg  <= lat_next;
            longitude_reg <= g2_side[31:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign radius       = radius_reg;
    assign latitude     = latitude_reg;
    assign longitude    = longitude_reg;

`ifndef ASSERT_OFF
    a_lat_range : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(latitude) <= LAT_MAX) && ($signed(latitude) >= LAT_MIN))
        else $error("latitude outside quarter turn");

    a_entry_load : assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> prep_ctl_reg.valid)
        else $error("accepted transaction not held in input register");

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(v2_ctl[CORDIC_STAGES].valid) && $stable(g1_ctl.valid))
        else $error("pipeline advanced during stall");

    a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
        pipe_en && !g2_ctl.valid |=> !result_valid)
        else $error("result raised without a transaction in flight");
`endif

endmodule

`default_nettype wire
